[src/sha256_pkg.sv]
// Shared constants, control struct and SHA-256 sigma functions.
// Used by the message schedule, the round core and the top level.
package sha256_pkg;

  // Padding and block layout
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_OFS  = 6'd56;
  localparam logic [5:0] LAST_OFS = 6'd63;
  localparam logic [5:0] LAST_RND = 6'd63;
  localparam logic [2:0] LAST_IDX = 3'd7;
  localparam logic [63:0] BYTE_BITS = 64'd8;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Round core control from the sequencer
  typedef struct packed {
    logic load;     // copy hash words into working vars
    logic round;    // run one compression round
    logic fold;     // add working vars into hash words
    logic restart;  // back to initial hash words
  } core_ctrl_t;

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

[src/sha256_hash_engine_unit.sv]
// SHA-256 engine top: byte intake, padding sequencer, digest output.
// Depends on sha256_pkg, sha256_msg_sched and sha256_round_core.
// Throughput: one byte per cycle while in_ready (idle); no intake while a completed block is
// compressed in 64 rounds on the shared round unit plus one fold. Last word: padding bytes to
// the block end, compression, one more block if fill is 56 or more, then 8 digest words.
// Reset (rst_n low, synchronous) sets initial hash words and clears counters; buffer not cleared.
module sha256_hash_engine_unit
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_no_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_COMP = 5'b00010,
    ST_FOLD = 5'b00100,
    ST_PAD  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        fin_r, fin_nxt;
  logic        pad_act_r, pad_act_nxt;
  logic        pad_first_r, pad_first_nxt;
  logic        len_ok_r, len_ok_nxt;

  logic        in_acc, out_acc;
  logic        wr_en, shift;
  logic [7:0]  wr_byte, len_byte;
  logic [2:0]  len_sel;
  logic [31:0] w_cur;
  core_ctrl_t  ctrl;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  // length field byte, most significant first
  assign len_sel  = ~fill_r[2:0];
  assign len_byte = bits_r[{len_sel, 3'b000} +: 8];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    bits_nxt      = bits_r;
    rnd_nxt       = rnd_r;
    idx_nxt       = idx_r;
    fin_nxt       = fin_r;
    pad_act_nxt   = pad_act_r;
    pad_first_nxt = pad_first_r;
    len_ok_nxt    = len_ok_r;
    wr_en         = 1'b0;
    wr_byte       = in_data_byte;
    shift         = 1'b0;
    ctrl          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_no_byte) begin
            wr_en    = 1'b1;
            fill_nxt = fill_r + 6'd1;
            bits_nxt = bits_r + BYTE_BITS;
          end
          if (in_last) begin
            pad_act_nxt   = 1'b1;
            pad_first_nxt = 1'b1;
          end
          if (!in_no_byte && fill_r == LAST_OFS) begin
            state_nxt = ST_COMP;
            fin_nxt   = 1'b0;
            ctrl.load = 1'b1;
          end else if (in_last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        wr_en = 1'b1;
        if (pad_first_r) begin
          wr_byte    = PAD_MARK;
          len_ok_nxt = (fill_r < LEN_OFS);
        end else if (len_ok_r && fill_r >= LEN_OFS) begin
          wr_byte = len_byte;
        end else begin
          wr_byte = '0;
        end
        pad_first_nxt = 1'b0;
        fill_nxt      = fill_r + 6'd1;
        if (fill_r == LAST_OFS) begin
          state_nxt = ST_COMP;
          fin_nxt   = len_ok_nxt;
          ctrl.load = 1'b1;
        end
      end
      ST_COMP: begin
        ctrl.round = 1'b1;
        shift      = 1'b1;
        rnd_nxt    = rnd_r + 6'd1;
        if (rnd_r == LAST_RND) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        ctrl.fold  = 1'b1;
        len_ok_nxt = 1'b1;
        if (fin_r) begin
          state_nxt = ST_OUT;
          idx_nxt   = '0;
        end else if (pad_act_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == LAST_IDX) begin
            ctrl.restart = 1'b1;
            fill_nxt     = '0;
            bits_nxt     = '0;
            pad_act_nxt  = 1'b0;
            fin_nxt      = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      bits_r      <= '0;
      rnd_r       <= '0;
      idx_r       <= '0;
      fin_r       <= 1'b0;
      pad_act_r   <= 1'b0;
      pad_first_r <= 1'b0;
      len_ok_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      bits_r      <= bits_nxt;
      rnd_r       <= rnd_nxt;
      idx_r       <= idx_nxt;
      fin_r       <= fin_nxt;
      pad_act_r   <= pad_act_nxt;
      pad_first_r <= pad_first_nxt;
      len_ok_r    <= len_ok_nxt;
    end
  end

  sha256_msg_sched u_sched (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r),
    .wr_byte (wr_byte),
    .shift   (shift),
    .w_cur   (w_cur)
  );

  sha256_round_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .rnd     (rnd_r),
    .w_cur   (w_cur),
    .rd_idx  (idx_r),
    .rd_word (out_digest_word)
  );

  assign out_word_index = idx_r;
  assign out_last_word  = (idx_r == LAST_IDX);

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("intake and digest output both open");

  a_last_round: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP && rnd_r == LAST_RND) |=> (state_r == ST_FOLD))
    else $error("fold did not follow the last round");

  a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_word_index == 3'd0))
    else $error("digest does not start at word 0");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_word) |=> (fill_r == '0 && bits_r == '0 && in_ready))
    else $error("message state not cleared after digest");

endmodule

[src/sha256_msg_sched.sv]
// Block buffer and message schedule: 16-word window, byte writes, shift per round.
// Depends on sha256_pkg.
module sha256_msg_sched
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        wr_en,
  input  logic [5:0]  wr_addr,
  input  logic [7:0]  wr_byte,
  input  logic        shift,
  output logic [31:0] w_cur
);

  logic [31:0] win_r [16];
  logic [31:0] w_new;

  // next schedule word from the window taps
  assign w_new = small_sig1(win_r[14]) + win_r[9] + small_sig0(win_r[1]) + win_r[0];
  assign w_cur = win_r[0];

  // byte fill (big-endian within a word) or window shift
  always_ff @(posedge clk) begin
    if (shift) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= w_new;
    end else if (wr_en) begin
      win_r[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
    end
  end

endmodule

[src/sha256_round_core.sv]
// Shared SHA-256 round unit with working variables and hash words.
// Depends on sha256_pkg.
module sha256_round_core
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  core_ctrl_t  ctrl,
  input  logic [5:0]  rnd,
  input  logic [31:0] w_cur,
  input  logic [2:0]  rd_idx,
  output logic [31:0] rd_word
);

  logic [31:0] hash_r [8];
  logic [31:0] var_r  [8];
  logic [31:0] t1, t2, ch, maj;

  // one round
  always_comb begin
    ch  = (var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6]);
    maj = (var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]);
    t1  = var_r[7] + big_sig1(var_r[4]) + ch + ROUND_K[rnd] + w_cur;
    t2  = big_sig0(var_r[0]) + maj;
  end

  // working variables
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      var_r <= hash_r;
    end else if (ctrl.round) begin
      var_r[7] <= var_r[6];
      var_r[6] <= var_r[5];
      var_r[5] <= var_r[4];
      var_r[4] <= var_r[3] + t1;
      var_r[3] <= var_r[2];
      var_r[2] <= var_r[1];
      var_r[1] <= var_r[0];
      var_r[0] <= t1 + t2;
    end
  end

  // hash words
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.restart) begin
      hash_r <= INIT_HASH;
    end else if (ctrl.fold) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= hash_r[i] + var_r[i];
      end
    end
  end

  assign rd_word = hash_r[rd_idx];

endmodule
